FILE: rtl/core/asa_pkg.sv
// Package for the accelerated setpoint adjuster.
// Holds the shared types, field and mode codes, step tables and limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package asa_pkg;

   localparam int TEMP_W  = 10;
   localparam int TIME_W  = 19;
   localparam int HUM_W   = 7;
   localparam int COUNT_W = 5;
   localparam int FIELD_W = 2;
   localparam int INDEX_W = 2;

   localparam logic       MODE_PRESS  = 1'b0;
   localparam logic       MODE_REPEAT = 1'b1;

   localparam logic [FIELD_W-1:0] FIELD_TEMP = 2'd0;
   localparam logic [FIELD_W-1:0] FIELD_TIME = 2'd1;
   localparam logic [FIELD_W-1:0] FIELD_HUM  = 2'd2;

   localparam logic [INDEX_W-1:0] REG_HUM_MIN = 2'd0;
   localparam logic [INDEX_W-1:0] REG_HUM_MAX = 2'd1;

   localparam logic [COUNT_W-1:0] COUNT_FINE  = 5'd5;
   localparam logic [COUNT_W-1:0] COUNT_MID   = 5'd15;
   localparam logic [COUNT_W-1:0] COUNT_SAT   = 5'd25;

   localparam logic [TEMP_W:0] TEMP_STEP_0 = 11'd1;
   localparam logic [TEMP_W:0] TEMP_STEP_1 = 11'd10;
   localparam logic [TEMP_W:0] TEMP_STEP_2 = 11'd20;
   localparam logic [TEMP_W:0] TEMP_STEP_3 = 11'd50;
   localparam logic [TEMP_W:0] TEMP_HALF   = 11'd5;
   localparam logic [TEMP_W:0] TEMP_MIN    = 11'd200;
   localparam logic [TEMP_W:0] TEMP_MAX    = 11'd800;
   localparam logic [TEMP_W:0] TEMP_RESET  = 11'd600;

   // x / 10 == (x * 205) >> 11 for every x below 1029
   localparam logic [7:0]      TEMP_DIV_MUL   = 8'd205;
   localparam int              TEMP_DIV_SHIFT = 11;

   localparam logic [TIME_W-1:0] TIME_STEP_0 = 19'(60);
   localparam logic [TIME_W-1:0] TIME_STEP_1 = 19'(5 * 60);
   localparam logic [TIME_W-1:0] TIME_STEP_2 = 19'(10 * 60);
   localparam logic [TIME_W-1:0] TIME_STEP_3 = 19'(30 * 60);
   localparam logic [TIME_W-1:0] TIME_MIN    = 19'(60);
   localparam logic [TIME_W-1:0] TIME_MAX    = 19'(99 * 3600 + 59 * 60);
   localparam logic [TIME_W-1:0] TIME_RESET  = 19'(3600);

   localparam logic [HUM_W-1:0] HUM_RESET     = 7'd0;
   localparam logic [HUM_W-1:0] HUM_MIN_RESET = 7'd30;
   localparam logic [HUM_W-1:0] HUM_MAX_RESET = 7'd90;

   typedef struct packed {
      logic                 mode;
      logic                 up;
      logic [FIELD_W-1:0]   field;
   } cmd_type;

   typedef struct packed {
      logic                 up;
      logic [FIELD_W-1:0]   field;
      logic [COUNT_W-1:0]   count;
   } hold_type;

   typedef struct packed {
      logic [TEMP_W-1:0]    temp;
      logic [TIME_W-1:0]    secs;
      logic [HUM_W-1:0]     hum;
   } setpt_type;

endpackage

`default_nettype wire

FILE: rtl/core/asa_step.sv
// Next-value logic for one item of the setpoint adjuster.
// Steps the chosen field (by hold count, humidity by one), then clamps.
// Depends on asa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asa_step (
   input  asa_pkg::cmd_type              cmd,
   input  asa_pkg::hold_type             hold,
   input  asa_pkg::setpt_type            cur,
   input  logic [asa_pkg::HUM_W-1:0]     hum_min,
   input  logic [asa_pkg::HUM_W-1:0]     hum_max,
   output asa_pkg::hold_type             hold_nxt,
   output asa_pkg::setpt_type            nxt
);

   logic                            eff_up;
   logic [asa_pkg::FIELD_W-1:0]     eff_field;
   logic [asa_pkg::COUNT_W-1:0]     cnt;

   logic [asa_pkg::TEMP_W:0]        t_cur;
   logic [asa_pkg::TEMP_W:0]        t_step;
   logic [asa_pkg::TEMP_W:0]        t_adj;
   logic [asa_pkg::TEMP_W:0]        t_half;
   logic [18:0]                     t_prod;
   logic [7:0]                      t_quot;
   logic [asa_pkg::TEMP_W:0]        t_rnd;
   logic [asa_pkg::TEMP_W:0]        t_fin;

   logic [asa_pkg::TIME_W-1:0]      s_step;
   logic [asa_pkg::TIME_W-1:0]      s_adj;
   logic [asa_pkg::TIME_W-1:0]      s_fin;

   logic [asa_pkg::HUM_W:0]         h_up;
   logic [asa_pkg::HUM_W-1:0]       h_fin;

   always_comb begin
      if (cmd.mode == asa_pkg::MODE_PRESS) begin
         eff_up    = cmd.up;
         eff_field = cmd.field;
         cnt       = '0;
      end else begin
         eff_up    = hold.up;
         eff_field = hold.field;
         cnt       = hold.count;
      end
   end

   always_comb begin
      priority if (cnt < asa_pkg::COUNT_FINE) begin
         t_step = asa_pkg::TEMP_STEP_0;
         s_step = asa_pkg::TIME_STEP_0;
      end else if (cnt < asa_pkg::COUNT_MID) begin
         t_step = asa_pkg::TEMP_STEP_1;
         s_step = asa_pkg::TIME_STEP_1;
      end else if (cnt < asa_pkg::COUNT_SAT) begin
         t_step = asa_pkg::TEMP_STEP_2;
         s_step = asa_pkg::TIME_STEP_2;
      end else begin
         t_step = asa_pkg::TEMP_STEP_3;
         s_step = asa_pkg::TIME_STEP_3;
      end
   end

   // temperature
   always_comb begin
      t_cur = {1'b0, cur.temp};
      if (eff_up) begin
         t_adj = t_cur + t_step;
      end else if (t_cur > t_step) begin
         t_adj = t_cur - t_step;
      end else begin
         t_adj = '0;
      end
      t_half = t_adj + asa_pkg::TEMP_HALF;
      t_prod = 19'(t_half) * 19'(asa_pkg::TEMP_DIV_MUL);
      t_quot = t_prod[asa_pkg::TEMP_DIV_SHIFT +: 8];
      t_rnd  = 11'({t_quot, 3'b000}) + 11'({t_quot, 1'b0});
      t_fin  = (t_step >= asa_pkg::TEMP_STEP_1) ? t_rnd : t_adj;
      if (t_fin < asa_pkg::TEMP_MIN) begin
         t_fin = asa_pkg::TEMP_MIN;
      end
      if (t_fin > asa_pkg::TEMP_MAX) begin
         t_fin = asa_pkg::TEMP_MAX;
      end
   end

   // run time
   always_comb begin
      if (eff_up) begin
         s_adj = cur.secs + s_step;
      end else if (cur.secs > s_step) begin
         s_adj = cur.secs - s_step;
      end else begin
         s_adj = asa_pkg::TIME_MIN;
      end
      s_fin = s_adj;
      if (s_fin > asa_pkg::TIME_MAX) begin
         s_fin = asa_pkg::TIME_MAX;
      end
      if (s_fin < asa_pkg::TIME_MIN) begin
         s_fin = asa_pkg::TIME_MIN;
      end
   end

   // humidity
   always_comb begin
      h_up  = (cur.hum == '0) ? {1'b0, hum_min} : ({1'b0, cur.hum} + 8'd1);
      h_fin = h_up[asa_pkg::HUM_W-1:0];
      if (eff_up) begin
         if (h_up > {1'b0, hum_max}) begin
            h_fin = hum_max;
         end
      end else if (cur.hum <= hum_min) begin
         h_fin = '0;
      end else begin
         h_fin = cur.hum - 7'd1;
      end
   end

   always_comb begin
      nxt = cur;
      unique case (eff_field)
         asa_pkg::FIELD_TEMP: nxt.temp = t_fin[asa_pkg::TEMP_W-1:0];
         asa_pkg::FIELD_TIME: nxt.secs = s_fin;
         default:             nxt.hum  = h_fin;
      endcase
   end

   always_comb begin
      hold_nxt.up    = eff_up;
      hold_nxt.field = eff_field;
      hold_nxt.count = (cnt < asa_pkg::COUNT_SAT) ? cnt + 5'd1 : cnt;
   end

endmodule

`default_nettype wire

FILE: rtl/core/accelerated_setpoint_adjuster_unit.sv
// Top level of the accelerated setpoint adjuster: input register, setpoint
// state that doubles as the result register, humidity limit registers.
// Depends on asa_pkg and asa_step.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | mode, press_up, field_select
//   rsp     | out       | rsp_valid/rsp_ready  | temp_tenths, time_seconds, hum_pct
//   csr     | in        | csr_write_enable     | csr_index, csr_write_data
//
// One item per cycle unless the result stalls; the result is a registered output.
// The setpoint update sits between the input register and the setpoint
// registers, so a stalled result holds the next item in the input register.
// Synchronous reset restores the default setpoints and humidity limits.
`timescale 1ns / 1ps
`default_nettype none

module accelerated_setpoint_adjuster_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic                           req_press_up,
   input  logic [asa_pkg::FIELD_W-1:0]    req_field_select,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [asa_pkg::TEMP_W-1:0]     rsp_temp_tenths,
   output logic [asa_pkg::TIME_W-1:0]     rsp_time_seconds,
   output logic [asa_pkg::HUM_W-1:0]      rsp_hum_pct,
   input  logic                           csr_write_enable,
   input  logic [asa_pkg::INDEX_W-1:0]    csr_index,
   input  logic [asa_pkg::HUM_W-1:0]      csr_write_data
);

   logic                        in_valid_ff;
   asa_pkg::cmd_type            cmd_ff;
   logic                        out_valid_ff;
   asa_pkg::setpt_type          setpt_ff;
   asa_pkg::setpt_type          setpt_in;
   asa_pkg::hold_type           hold_ff;
   asa_pkg::hold_type           hold_in;
   logic [asa_pkg::HUM_W-1:0]   hum_min_ff;
   logic [asa_pkg::HUM_W-1:0]   hum_max_ff;
   logic                        advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   asa_step u_step (
      .cmd      (cmd_ff),
      .hold     (hold_ff),
      .cur      (setpt_ff),
      .hum_min  (hum_min_ff),
      .hum_max  (hum_max_ff),
      .hold_nxt (hold_in),
      .nxt      (setpt_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         setpt_ff.temp <= asa_pkg::TEMP_RESET[asa_pkg::TEMP_W-1:0];
         setpt_ff.secs <= asa_pkg::TIME_RESET;
         setpt_ff.hum  <= asa_pkg::HUM_RESET;
         hold_ff       <= '0;
         hum_min_ff    <= asa_pkg::HUM_MIN_RESET;
         hum_max_ff    <= asa_pkg::HUM_MAX_RESET;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            setpt_ff     <= setpt_in;
            hold_ff      <= hold_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            if (csr_index == asa_pkg::REG_HUM_MIN) begin
               hum_min_ff <= csr_write_data;
            end else if (csr_index == asa_pkg::REG_HUM_MAX) begin
               hum_max_ff <= csr_write_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff.mode  <= req_mode;
         cmd_ff.up    <= req_press_up;
         cmd_ff.field <= req_field_select;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_temp_tenths  = setpt_ff.temp;
   assign rsp_time_seconds = setpt_ff.secs;
   assign rsp_hum_pct      = setpt_ff.hum;

`ifndef NO_ASSERTIONS
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      (setpt_ff.temp >= 10'd200) && (setpt_ff.temp <= 10'd800))
      else $error("temperature setpoint out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (setpt_ff.secs >= asa_pkg::TIME_MIN) && (setpt_ff.secs <= asa_pkg::TIME_MAX))
      else $error("run time setpoint out of range");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      hold_ff.count <= asa_pkg::COUNT_SAT)
      else $error("hold count above saturation");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("updated item not shown on result port");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> $stable(setpt_ff) && $stable(hold_ff))
      else $error("setpoints changed while result stalled");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_accelerated_setpoint_adjuster_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for accelerated_setpoint_adjuster_unit: random button
// items and idling on both channels, every setpoint checked against a model.
// Depends on asa_pkg and the RTL of the unit.

module tb_accelerated_setpoint_adjuster_unit;

   localparam logic [asa_pkg::FIELD_W-1:0] FIELD_SPARE  = 2'd3;
   localparam logic [asa_pkg::INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
   localparam logic [asa_pkg::INDEX_W-1:0] REG_UNUSED_3 = 2'd3;
   localparam int NUM_PHASES   = 8;
   localparam int RANDOM_ITEMS = 55;
   localparam int LONG_HOLD    = 150;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 6;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_mode;
   logic                          req_press_up;
   logic [asa_pkg::FIELD_W-1:0]   req_field_select;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [asa_pkg::TEMP_W-1:0]    rsp_temp_tenths;
   logic [asa_pkg::TIME_W-1:0]    rsp_time_seconds;
   logic [asa_pkg::HUM_W-1:0]     rsp_hum_pct;
   logic                          csr_write_enable;
   logic [asa_pkg::INDEX_W-1:0]   csr_index;
   logic [asa_pkg::HUM_W-1:0]     csr_write_data;

   asa_pkg::cmd_type   button_items[$];
   asa_pkg::setpt_type expected_setpts[$];

   // model of the panel state
   logic [asa_pkg::TEMP_W-1:0]  set_temp;
   logic [asa_pkg::TIME_W-1:0]  set_secs;
   logic [asa_pkg::HUM_W-1:0]   set_hum;
   logic                        latch_up;
   logic [asa_pkg::FIELD_W-1:0] latch_field;
   logic [asa_pkg::COUNT_W-1:0] hold_count;
   logic [asa_pkg::HUM_W-1:0]   hum_floor;
   logic [asa_pkg::HUM_W-1:0]   hum_ceiling;

   logic               req_fire;
   logic               rsp_fire;
   int                 req_accepted = 0;
   int                 failures = 0;
   int                 quiet_cycles = 0;
   int                 req_gap;
   int                 rsp_stall;
   int                 rsp_hold_left;
   bit                 rsp_hold_used = 1'b0;
   int                 hold_rsp_at;
   int                 req_idle_max;
   int                 rsp_idle_max;
   asa_pkg::cmd_type   drive_cmd;
   asa_pkg::setpt_type seen_setpt;

   accelerated_setpoint_adjuster_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_press_up     (req_press_up),
      .req_field_select (req_field_select),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_temp_tenths  (rsp_temp_tenths),
      .rsp_time_seconds (rsp_time_seconds),
      .rsp_hum_pct      (rsp_hum_pct),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic apply_button_item(input asa_pkg::cmd_type item);
      int unsigned step;
      int unsigned value;
      if (item.mode == asa_pkg::MODE_PRESS) begin
         latch_up    = item.up;
         latch_field = item.field;
         hold_count  = '0;
      end
      if (latch_field == asa_pkg::FIELD_TEMP) begin
         if (hold_count < asa_pkg::COUNT_FINE) step = 32'(asa_pkg::TEMP_STEP_0);
         else if (hold_count < asa_pkg::COUNT_MID) step = 32'(asa_pkg::TEMP_STEP_1);
         else if (hold_count < asa_pkg::COUNT_SAT) step = 32'(asa_pkg::TEMP_STEP_2);
         else step = 32'(asa_pkg::TEMP_STEP_3);
         value = 32'(set_temp);
         if (latch_up) value = value + step;
         else value = (value > step) ? value - step : 0;
         if (step >= asa_pkg::TEMP_STEP_1)
            value = (value + 32'(asa_pkg::TEMP_HALF)) / 10 * 10;
         if (value < asa_pkg::TEMP_MIN) value = 32'(asa_pkg::TEMP_MIN);
         if (value > asa_pkg::TEMP_MAX) value = 32'(asa_pkg::TEMP_MAX);
         set_temp = asa_pkg::TEMP_W'(value);
      end else if (latch_field == asa_pkg::FIELD_TIME) begin
         if (hold_count < asa_pkg::COUNT_FINE) step = 32'(asa_pkg::TIME_STEP_0);
         else if (hold_count < asa_pkg::COUNT_MID) step = 32'(asa_pkg::TIME_STEP_1);
         else if (hold_count < asa_pkg::COUNT_SAT) step = 32'(asa_pkg::TIME_STEP_2);
         else step = 32'(asa_pkg::TIME_STEP_3);
         value = 32'(set_secs);
         if (latch_up) value = value + step;
         else if (value > step) value = value - step;
         else value = 32'(asa_pkg::TIME_MIN);
         if (value > asa_pkg::TIME_MAX) value = 32'(asa_pkg::TIME_MAX);
         if (value < asa_pkg::TIME_MIN) value = 32'(asa_pkg::TIME_MIN);
         set_secs = asa_pkg::TIME_W'(value);
      end else begin
         value = 32'(set_hum);
         if (latch_up) begin
            value = (value == 0) ? 32'(hum_floor) : value + 1;
            if (value > hum_ceiling) value = 32'(hum_ceiling);
         end else begin
            value = (value <= hum_floor) ? 0 : value - 1;
         end
         set_hum = asa_pkg::HUM_W'(value);
      end
      if (hold_count < asa_pkg::COUNT_SAT) hold_count = hold_count + 1'b1;
   endtask

   // model, checker and handshake flags
   always @(posedge clock) begin
      if (reset) begin
         set_temp    = asa_pkg::TEMP_RESET[asa_pkg::TEMP_W-1:0];
         set_secs    = asa_pkg::TIME_RESET;
         set_hum     = asa_pkg::HUM_RESET;
         latch_up    = 1'b0;
         latch_field = asa_pkg::FIELD_TEMP;
         hold_count  = '0;
         hum_floor   = asa_pkg::HUM_MIN_RESET;
         hum_ceiling = asa_pkg::HUM_MAX_RESET;
         req_fire   <= 1'b0;
         rsp_fire   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               asa_pkg::REG_HUM_MIN: hum_floor = csr_write_data;
               asa_pkg::REG_HUM_MAX: hum_ceiling = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_setpts.size() == 0) begin
               $display("%0t: unexpected result temp %0d time %0d hum %0d", $time,
                        rsp_temp_tenths, rsp_time_seconds, rsp_hum_pct);
               failures++;
            end else begin
               seen_setpt = expected_setpts.pop_front();
               if (rsp_temp_tenths !== seen_setpt.temp) begin
                  $display("%0t: temp_tenths expected %0d actual %0d", $time,
                           seen_setpt.temp, rsp_temp_tenths);
                  failures++;
               end
               if (rsp_time_seconds !== seen_setpt.secs) begin
                  $display("%0t: time_seconds expected %0d actual %0d", $time,
                           seen_setpt.secs, rsp_time_seconds);
                  failures++;
               end
               if (rsp_hum_pct !== seen_setpt.hum) begin
                  $display("%0t: hum_pct expected %0d actual %0d", $time,
                           seen_setpt.hum, rsp_hum_pct);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_button_item('{mode: req_mode, up: req_press_up, field: req_field_select});
            expected_setpts.push_back('{temp: set_temp, secs: set_secs, hum: set_hum});
            req_accepted++;
         end
         req_fire <= req_valid && req_ready;
         rsp_fire <= rsp_valid && rsp_ready;
      end
   end

   // sender: hold the item until taken, then idle a drawn number of cycles
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (button_items.size() > 0) begin
            drive_cmd = button_items.pop_front();
            req_mode         <= drive_cmd.mode;
            req_press_up     <= drive_cmd.up;
            req_field_select <= drive_cmd.field;
            req_valid        <= 1'b1;
            req_gap = $urandom_range(0, req_idle_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off to back up the pipe
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
         rsp_hold_left = 0;
      end else begin
         if (rsp_fire) rsp_stall = $urandom_range(0, rsp_idle_max);
         if (!rsp_hold_used && req_accepted == hold_rsp_at) begin
            rsp_hold_used = 1'b1;
            rsp_hold_left = LONG_HOLD;
         end
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic write_csr(input logic [asa_pkg::INDEX_W-1:0] index,
                            input logic [asa_pkg::HUM_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic queue_repeat();
      button_items.push_back('{mode: asa_pkg::MODE_REPEAT, up: 1'($urandom_range(0, 1)),
                               field: asa_pkg::FIELD_W'($urandom_range(0, 3))});
   endtask

   task automatic queue_hold(input logic up, input logic [asa_pkg::FIELD_W-1:0] field,
                             input int repeats);
      button_items.push_back('{mode: asa_pkg::MODE_PRESS, up: up, field: field});
      repeat (repeats) queue_repeat();
   endtask

   task automatic queue_random_holds(input int count);
      int added;
      int repeats;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 9) == 0) begin
            button_items.push_back(asa_pkg::cmd_type'(4'($urandom_range(0, 15))));
            added++;
         end else begin
            repeats = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 8);
            queue_hold(1'($urandom_range(0, 1)), asa_pkg::FIELD_W'($urandom_range(0, 3)),
                       repeats);
            added += repeats + 1;
         end
      end
   endtask

   task automatic wait_for_drain();
      while (button_items.size() > 0 || req_valid || expected_setpts.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   int floor_set[NUM_PHASES]   = '{30, 1, 0, 100, 127, 0, 50, 30};
   int ceiling_set[NUM_PHASES] = '{90, 100, 127, 1, 127, 0, 55, 90};

   initial begin
      reset            = 1'b1;
      req_mode         = asa_pkg::MODE_PRESS;
      req_press_up     = 1'b0;
      req_field_select = asa_pkg::FIELD_TEMP;
      csr_write_enable = 1'b0;
      csr_index        = asa_pkg::REG_HUM_MIN;
      csr_write_data   = '0;
      hold_rsp_at      = -1;
      req_idle_max     = 6;
      rsp_idle_max     = 6;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            write_csr(asa_pkg::REG_HUM_MIN, asa_pkg::HUM_W'(floor_set[p]));
            write_csr(asa_pkg::REG_HUM_MAX, asa_pkg::HUM_W'(ceiling_set[p]));
            write_csr(p[0] ? REG_UNUSED_3 : REG_UNUSED_2,
                      asa_pkg::HUM_W'($urandom_range(0, 127)));
         end
         req_idle_max = (p % 3 == 2) ? 0 : 6;
         rsp_idle_max = (p % 4 == 1) ? 0 : 6;
         if (p == 0) begin
            queue_repeat();
            queue_hold(1'b1, asa_pkg::FIELD_TEMP, 6);
            queue_hold(1'b0, asa_pkg::FIELD_TEMP, 6);
            queue_hold(1'b0, asa_pkg::FIELD_TIME, 0);
            queue_hold(1'b1, asa_pkg::FIELD_TIME, 1);
            queue_hold(1'b1, asa_pkg::FIELD_HUM, 1);
            queue_hold(1'b0, asa_pkg::FIELD_HUM, 0);
            queue_hold(1'b0, asa_pkg::FIELD_HUM, 1);
            queue_hold(1'b1, FIELD_SPARE, 0);
            queue_hold(1'b0, FIELD_SPARE, 0);
         end
         if (p == 1) begin
            queue_hold(1'b1, asa_pkg::FIELD_TIME, 210);
            queue_hold(1'b0, asa_pkg::FIELD_TIME, 40);
         end
         if (p == 3) hold_rsp_at = req_accepted + 10;
         queue_random_holds(RANDOM_ITEMS);
         wait_for_drain();
      end

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/asa_pkg.sv
rtl/core/asa_step.sv
rtl/core/accelerated_setpoint_adjuster_unit.sv
tb/sv/tb_accelerated_setpoint_adjuster_unit.sv
